// File: design/assert_macros.svh
// assertion macros used by the core rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ptpc_pkg.sv
// shared types, widths and codes of the point-triangle contact core
`default_nettype none

package ptpc_pkg;

  // storage and field widths
  localparam int TRIANGLES  = 1024;
  localparam int SLOT_W     = 10;
  localparam int SCAN_W     = SLOT_W + 1;
  localparam int COORD_W    = 16;
  localparam int CORNER_W   = 3 * COORD_W;
  localparam int EDGE_W     = COORD_W + 1;
  localparam int CROSS_W    = 2 * EDGE_W + 1;
  localparam int DPROD_W    = CROSS_W + EDGE_W;
  localparam int DIST_W     = DPROD_W + 2;
  localparam int BPROD_W    = 2 * CROSS_W;
  localparam int BARY_W     = BPROD_W + 2;
  localparam int EPS_W      = 55;
  localparam int GAIN_W     = 16;
  localparam int OFF_W      = 12;
  localparam int DEPTH_W    = 56;
  localparam int FORCE_W    = 32;
  localparam int GN_W       = GAIN_W + CROSS_W;
  localparam int DLO_W      = 28;
  localparam int GLO_W      = 26;
  localparam int ACC_W      = 108;
  localparam int FORCE_SHIFT = 52;
  localparam int FSAT_W     = ACC_W - FORCE_SHIFT;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 64;

  // divide by three through a reciprocal, exact for sums below 8192
  localparam int DIV3_MUL   = 10923;
  localparam int DIV3_SHIFT = 15;

  // reset values of the registers
  localparam logic [EPS_W-1:0]  EPS_RESET  = 55'd6871947674;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd2560;

  // item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // corner codes
  localparam logic [1:0] CORNER_A = 2'd0;
  localparam logic [1:0] CORNER_B = 2'd1;
  localparam logic [1:0] CORNER_C = 2'd2;

  // register indexes
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_GAIN      = 2'd1;
  localparam logic [1:0] REG_OFFSET    = 2'd2;
  localparam logic [1:0] REG_LENGTH    = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [EDGE_W-1:0]  edge_t;
  typedef logic signed [CROSS_W-1:0] cross_t;

  // one component of a cross product: ai*bj - aj*bi
  function automatic cross_t cross_comp(input edge_t ai, input edge_t bj,
                                        input edge_t aj, input edge_t bi);
    cross_comp = CROSS_W'(ai * bj) - CROSS_W'(aj * bi);
  endfunction

endpackage

`default_nettype wire

// File: design/ptpc_in_if.sv
// input channel: triangle corner loads and query points
`default_nettype none

interface ptpc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [ptpc_pkg::SLOT_W-1:0]   tri_slot;
  logic [1:0]                    corner;
  logic signed [ptpc_pkg::COORD_W-1:0] coord_x;
  logic signed [ptpc_pkg::COORD_W-1:0] coord_y;
  logic signed [ptpc_pkg::COORD_W-1:0] coord_z;

  modport source (output valid, kind, tri_slot, corner, coord_x, coord_y, coord_z,
                  input ready);
  modport sink (input valid, kind, tri_slot, corner, coord_x, coord_y, coord_z,
                output ready);
endinterface

`default_nettype wire

// File: design/ptpc_out_if.sv
// result channel: contact flag, triangle, depth and penalty force
`default_nettype none

interface ptpc_out_if;
  logic                                valid;
  logic                                ready;
  logic                                hit;
  logic [ptpc_pkg::SLOT_W-1:0]         hit_slot;
  logic signed [ptpc_pkg::DEPTH_W-1:0] depth;
  logic signed [ptpc_pkg::FORCE_W-1:0] force_x;
  logic signed [ptpc_pkg::FORCE_W-1:0] force_y;
  logic signed [ptpc_pkg::FORCE_W-1:0] force_z;

  modport source (output valid, hit, hit_slot, depth, force_x, force_y, force_z,
                  input ready);
  modport sink (input valid, hit, hit_slot, depth, force_x, force_y, force_z,
                output ready);
endinterface

`default_nettype wire

// File: design/point_triangle_penalty_contact_core.sv
// point-triangle proximity contact core: triangle store, scan pipeline, force unit
//
//   channel  dir  handshake          beat
//   in_ch    in   valid/ready        corner load or query point
//   out_ch   out  valid/ready        one result per query
//   cfg      in   apb psel/penable   register write or read
//
// a load beat writes one corner of the triangle store; corner code three writes none.
// a query scans one stored triangle per cycle through a five-stage test pipeline
// up to the end of its range or to the first contact, then the shared force
// multiplier forms the force of each axis in turn.
// rst_n is synchronous; the store is not cleared, only control state.
// the result sits in an output register; a new beat is taken while it waits.
`default_nettype none
`include "assert_macros.svh"

module point_triangle_penalty_contact_core (
  input  wire logic clk,
  input  wire logic rst_n,
  ptpc_in_if.sink   in_ch,
  ptpc_out_if.source out_ch,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [ptpc_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [ptpc_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic      [ptpc_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                     pready
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FORCE, ST_DONE} state_t;

  // configuration registers
  logic [ptpc_pkg::EPS_W-1:0]  eps_r;
  logic [ptpc_pkg::GAIN_W-1:0] gain_r;
  logic [ptpc_pkg::OFF_W-1:0]  offset_r;
  logic [ptpc_pkg::OFF_W-1:0]  length_r;
  logic                        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r    <= ptpc_pkg::EPS_RESET;
      gain_r   <= ptpc_pkg::GAIN_RESET;
      offset_r <= '0;
      length_r <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:3])
        ptpc_pkg::REG_THRESHOLD: eps_r    <= pwdata[ptpc_pkg::EPS_W-1:0];
        ptpc_pkg::REG_GAIN:      gain_r   <= pwdata[ptpc_pkg::GAIN_W-1:0];
        ptpc_pkg::REG_OFFSET:    offset_r <= pwdata[ptpc_pkg::OFF_W-1:0];
        ptpc_pkg::REG_LENGTH:    length_r <= pwdata[ptpc_pkg::OFF_W-1:0];
        default: ;
      endcase
    end
  end

  // register read mux
  always_comb begin
    case (paddr[4:3])
      ptpc_pkg::REG_THRESHOLD: prdata = 64'(eps_r);
      ptpc_pkg::REG_GAIN:      prdata = 64'(gain_r);
      ptpc_pkg::REG_OFFSET:    prdata = 64'(offset_r);
      ptpc_pkg::REG_LENGTH:    prdata = 64'(length_r);
      default:                 prdata = '0;
    endcase
  end

  // control state
  state_t                        state_r;
  logic                          found_r;
  logic [ptpc_pkg::SCAN_W-1:0]   scan_j_r;
  logic [ptpc_pkg::SCAN_W-1:0]   scan_end_r;
  logic [4:0]                    pipe_v_r;
  logic                          iss;
  logic                          in_acc;
  logic                          is_query;
  logic                          is_load;
  logic                          out_load;
  logic                          out_valid_r;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign is_query    = in_acc && (in_ch.kind == ptpc_pkg::KIND_QUERY);
  assign is_load     = in_acc && (in_ch.kind == ptpc_pkg::KIND_LOAD);
  assign iss         = (state_r == ST_SCAN) && !found_r && (scan_j_r < scan_end_r);
  assign out_load    = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  // scan bounds: offset / 3 and (offset + length) / 3 by reciprocal
  logic [25:0]                 start_prod;
  logic [26:0]                 stop_prod;
  logic [ptpc_pkg::OFF_W-1:0]  stop_idx;
  logic [ptpc_pkg::SCAN_W-1:0] end_idx;

  always_comb begin
    start_prod = 26'(offset_r) * 26'(ptpc_pkg::DIV3_MUL);
    stop_prod  = 27'(13'(offset_r) + 13'(length_r)) * 27'(ptpc_pkg::DIV3_MUL);
    stop_idx   = stop_prod[26:ptpc_pkg::DIV3_SHIFT];
    end_idx    = (stop_idx > ptpc_pkg::OFF_W'(ptpc_pkg::TRIANGLES))
                 ? ptpc_pkg::SCAN_W'(ptpc_pkg::TRIANGLES)
                 : stop_idx[ptpc_pkg::SCAN_W-1:0];
  end

  // triangle store, one ram per corner
  logic [ptpc_pkg::CORNER_W-1:0] rd_corner [3];
  logic [ptpc_pkg::CORNER_W-1:0] wr_corner;

  assign wr_corner = {in_ch.coord_z, in_ch.coord_y, in_ch.coord_x};

  for (genvar c = 0; c < 3; c++) begin : g_store
    ptpc_ram #(
      .WIDTH (ptpc_pkg::CORNER_W),
      .DEPTH (ptpc_pkg::TRIANGLES)
    ) u_ram (
      .clk   (clk),
      .we    (is_load && (in_ch.corner == 2'(c))),
      .waddr (in_ch.tri_slot),
      .wdata (wr_corner),
      .raddr (scan_j_r[ptpc_pkg::SLOT_W-1:0]),
      .rdata (rd_corner[c])
    );
  end

  // query point
  ptpc_pkg::coord_t p_r [3];

  always_ff @(posedge clk) begin
    if (is_query) begin
      p_r[0] <= in_ch.coord_x;
      p_r[1] <= in_ch.coord_y;
      p_r[2] <= in_ch.coord_z;
    end
  end

  // pipeline data
  logic [ptpc_pkg::SLOT_W-1:0] j0_r, j1_r, j2_r, j3_r, j4_r;
  ptpc_pkg::edge_t  e1_r [3], e2_r [3], ecb_r [3], pa1_r [3], pb_r [3], pa2_r [3];
  ptpc_pkg::cross_t n2_r [3], t1_r [3], t2_r [3], t3_r [3], n3_r [3], n4_r [3];
  logic signed [ptpc_pkg::DPROD_W-1:0] pd_r [3];
  logic signed [ptpc_pkg::BPROD_W-1:0] pu_r [3], pv_r [3], pw_r [3];
  logic signed [ptpc_pkg::DIST_W-1:0]  dist4_r;
  logic                                hit4_r;

  // stage 1 operands: corners unpacked from the store
  ptpc_pkg::coord_t ca [3], cb [3], cc [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ca[k] = rd_corner[0][k*ptpc_pkg::COORD_W +: ptpc_pkg::COORD_W];
      cb[k] = rd_corner[1][k*ptpc_pkg::COORD_W +: ptpc_pkg::COORD_W];
      cc[k] = rd_corner[2][k*ptpc_pkg::COORD_W +: ptpc_pkg::COORD_W];
    end
  end

  // stage 4 sums and contact test
  logic signed [ptpc_pkg::DIST_W-1:0] dist_s;
  logic signed [ptpc_pkg::BARY_W-1:0] u_s, v_s, w_s;
  logic signed [ptpc_pkg::EPS_W+1:0]  dist_x, eps_x;
  logic                               hit_s;

  always_comb begin
    dist_s = ptpc_pkg::DIST_W'(pd_r[0]) + ptpc_pkg::DIST_W'(pd_r[1])
           + ptpc_pkg::DIST_W'(pd_r[2]);
    u_s = ptpc_pkg::BARY_W'(pu_r[0]) + ptpc_pkg::BARY_W'(pu_r[1])
        + ptpc_pkg::BARY_W'(pu_r[2]);
    v_s = ptpc_pkg::BARY_W'(pv_r[0]) + ptpc_pkg::BARY_W'(pv_r[1])
        + ptpc_pkg::BARY_W'(pv_r[2]);
    w_s = ptpc_pkg::BARY_W'(pw_r[0]) + ptpc_pkg::BARY_W'(pw_r[1])
        + ptpc_pkg::BARY_W'(pw_r[2]);
    dist_x = (ptpc_pkg::EPS_W+2)'(dist_s);
    eps_x  = $signed({2'b00, eps_r});
    hit_s  = (dist_x <= eps_x) && (dist_x >= -eps_x) && !u_s[ptpc_pkg::BARY_W-1]
             && !v_s[ptpc_pkg::BARY_W-1] && !w_s[ptpc_pkg::BARY_W-1] && (w_s != '0);
  end

  // valid bits of the test pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_v_r <= '0;
    end else begin
      pipe_v_r <= {pipe_v_r[3:0], iss};
    end
  end

  // pipeline data stages
  always_ff @(posedge clk) begin
    j0_r <= scan_j_r[ptpc_pkg::SLOT_W-1:0];
    j1_r <= j0_r;
    j2_r <= j1_r;
    j3_r <= j2_r;
    j4_r <= j3_r;
    for (int k = 0; k < 3; k++) begin
      // edges and point offsets
      e1_r[k]  <= ptpc_pkg::EDGE_W'(cb[k]) - ptpc_pkg::EDGE_W'(ca[k]);
      e2_r[k]  <= ptpc_pkg::EDGE_W'(cc[k]) - ptpc_pkg::EDGE_W'(ca[k]);
      ecb_r[k] <= ptpc_pkg::EDGE_W'(cc[k]) - ptpc_pkg::EDGE_W'(cb[k]);
      pa1_r[k] <= ptpc_pkg::EDGE_W'(p_r[k]) - ptpc_pkg::EDGE_W'(ca[k]);
      pb_r[k]  <= ptpc_pkg::EDGE_W'(p_r[k]) - ptpc_pkg::EDGE_W'(cb[k]);
      pa2_r[k] <= pa1_r[k];
      // dot product terms
      pd_r[k]  <= ptpc_pkg::DPROD_W'(n2_r[k] * pa2_r[k]);
      pu_r[k]  <= ptpc_pkg::BPROD_W'(n2_r[k] * t1_r[k]);
      pv_r[k]  <= ptpc_pkg::BPROD_W'(n2_r[k] * t2_r[k]);
      pw_r[k]  <= ptpc_pkg::BPROD_W'(n2_r[k] * t3_r[k]);
      n3_r[k]  <= n2_r[k];
      n4_r[k]  <= n3_r[k];
    end
    // cross products: normal and barycentric numerator vectors
    n2_r[0] <= ptpc_pkg::cross_comp(e1_r[1], e2_r[2], e1_r[2], e2_r[1]);
    n2_r[1] <= ptpc_pkg::cross_comp(e1_r[2], e2_r[0], e1_r[0], e2_r[2]);
    n2_r[2] <= ptpc_pkg::cross_comp(e1_r[0], e2_r[1], e1_r[1], e2_r[0]);
    t1_r[0] <= ptpc_pkg::cross_comp(e1_r[1], pa1_r[2], e1_r[2], pa1_r[1]);
    t1_r[1] <= ptpc_pkg::cross_comp(e1_r[2], pa1_r[0], e1_r[0], pa1_r[2]);
    t1_r[2] <= ptpc_pkg::cross_comp(e1_r[0], pa1_r[1], e1_r[1], pa1_r[0]);
    t2_r[0] <= ptpc_pkg::cross_comp(pa1_r[1], e2_r[2], pa1_r[2], e2_r[1]);
    t2_r[1] <= ptpc_pkg::cross_comp(pa1_r[2], e2_r[0], pa1_r[0], e2_r[2]);
    t2_r[2] <= ptpc_pkg::cross_comp(pa1_r[0], e2_r[1], pa1_r[1], e2_r[0]);
    t3_r[0] <= ptpc_pkg::cross_comp(ecb_r[1], pb_r[2], ecb_r[2], pb_r[1]);
    t3_r[1] <= ptpc_pkg::cross_comp(ecb_r[2], pb_r[0], ecb_r[0], pb_r[2]);
    t3_r[2] <= ptpc_pkg::cross_comp(ecb_r[0], pb_r[1], ecb_r[1], pb_r[0]);
    // test result
    dist4_r <= dist_s;
    hit4_r  <= hit_s;
  end

  // force unit: gain * normal, then four partial products of depth * that
  logic [2:0]                          step_r;
  logic [1:0]                          comp_r;
  logic [ptpc_pkg::DEPTH_W-1:0]        dgap_r;
  logic signed [ptpc_pkg::GN_W-1:0]    gn_r;
  logic signed [ptpc_pkg::ACC_W-1:0]   acc_r;
  logic signed [ptpc_pkg::FORCE_W-1:0] force_r [3];
  logic [ptpc_pkg::SLOT_W-1:0]         cap_slot_r;
  logic signed [ptpc_pkg::DIST_W-1:0]  cap_dist_r;
  ptpc_pkg::cross_t                    cap_n_r [3];

  logic [ptpc_pkg::DLO_W-1:0]          d_op;
  logic signed [ptpc_pkg::GLO_W:0]     g_op;
  logic signed [ptpc_pkg::DLO_W+ptpc_pkg::GLO_W+1:0] part;
  logic signed [ptpc_pkg::ACC_W-1:0]   part_x, part_sh, rnd;
  logic signed [ptpc_pkg::FSAT_W-1:0]  f_s;
  logic signed [ptpc_pkg::FORCE_W-1:0] f_sat;
  logic signed [ptpc_pkg::GN_W:0]      gn_full;

  always_comb begin
    gn_full = $signed({1'b0, gain_r}) * cap_n_r[comp_r];
    d_op    = (step_r >= 3'd3) ? dgap_r[ptpc_pkg::DEPTH_W-1:ptpc_pkg::DLO_W]
                               : dgap_r[ptpc_pkg::DLO_W-1:0];
    g_op    = step_r[0] ? $signed({1'b0, gn_r[ptpc_pkg::GLO_W-1:0]})
                        : $signed({gn_r[ptpc_pkg::GN_W-1], gn_r[ptpc_pkg::GN_W-1:ptpc_pkg::GLO_W]});
    part    = $signed({1'b0, d_op}) * g_op;
    part_x  = ptpc_pkg::ACC_W'(part);
    case (step_r)
      3'd2:    part_sh = part_x <<< ptpc_pkg::GLO_W;
      3'd3:    part_sh = part_x <<< ptpc_pkg::DLO_W;
      3'd4:    part_sh = part_x <<< (ptpc_pkg::DLO_W + ptpc_pkg::GLO_W);
      default: part_sh = part_x;
    endcase
    rnd = acc_r + (ptpc_pkg::ACC_W'(1) <<< (ptpc_pkg::FORCE_SHIFT - 1));
    f_s = ptpc_pkg::FSAT_W'(rnd >>> ptpc_pkg::FORCE_SHIFT);
    if (f_s > ptpc_pkg::FSAT_W'(32'sh7fffffff)) begin
      f_sat = 32'sh7fffffff;
    end else if (f_s < -(ptpc_pkg::FSAT_W'(33'sh080000000))) begin
      f_sat = $signed(32'h80000000);
    end else begin
      f_sat = ptpc_pkg::FORCE_W'(f_s);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FORCE) begin
      if (step_r == 3'd0) begin
        gn_r  <= ptpc_pkg::GN_W'(gn_full);
        acc_r <= '0;
      end else if (step_r == 3'd5) begin
        force_r[comp_r] <= f_sat;
      end else begin
        acc_r <= acc_r + part_sh;
      end
    end
  end

  // capture of the first contact
  always_ff @(posedge clk) begin
    if ((state_r == ST_SCAN) && !found_r && pipe_v_r[4] && hit4_r) begin
      cap_slot_r <= j4_r;
      cap_dist_r <= dist4_r;
      dgap_r     <= ptpc_pkg::DEPTH_W'({2'b00, eps_r} - (ptpc_pkg::EPS_W+2)'(dist4_r));
      for (int k = 0; k < 3; k++) begin
        cap_n_r[k] <= n4_r[k];
      end
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      found_r     <= 1'b0;
      scan_j_r    <= '0;
      scan_end_r  <= '0;
      step_r      <= '0;
      comp_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (is_query) begin
            state_r    <= ST_SCAN;
            found_r    <= 1'b0;
            scan_j_r   <= ptpc_pkg::SCAN_W'(start_prod[25:ptpc_pkg::DIV3_SHIFT]);
            scan_end_r <= end_idx;
          end
        end
        ST_SCAN: begin
          if (iss) begin
            scan_j_r <= scan_j_r + 1'b1;
          end
          if (!found_r && pipe_v_r[4] && hit4_r) begin
            found_r <= 1'b1;
          end
          if (found_r) begin
            state_r <= ST_FORCE;
            step_r  <= '0;
            comp_r  <= '0;
          end else if (!iss && (pipe_v_r == '0)) begin
            state_r <= ST_DONE;
          end
        end
        ST_FORCE: begin
          if (step_r == 3'd5) begin
            step_r <= '0;
            if (comp_r == 2'd2) begin
              state_r <= ST_DONE;
            end else begin
              comp_r <= comp_r + 1'b1;
            end
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.hit      <= found_r;
      out_ch.hit_slot <= found_r ? cap_slot_r : '0;
      out_ch.depth    <= found_r ? ptpc_pkg::DEPTH_W'(cap_dist_r) : '0;
      out_ch.force_x  <= found_r ? force_r[0] : '0;
      out_ch.force_y  <= found_r ? force_r[1] : '0;
      out_ch.force_z  <= found_r ? force_r[2] : '0;
    end
  end

  assign out_ch.valid = out_valid_r;

  // checks
  `ASSERT_IMP(a_issue_in_range, iss, (scan_j_r < scan_end_r), "scan read past range end")
  `ASSERT_IMP(a_idle_pipe_empty, (state_r == ST_IDLE), (pipe_v_r == 5'd0), "pipeline busy in idle")
  `ASSERT_NXT(a_found_to_force, ((state_r == ST_SCAN) && found_r), (state_r == ST_FORCE), "contact not sent to force unit")
  `ASSERT_IMP(a_out_load_free, out_load, (!out_valid_r || out_ch.ready), "result overwrites pending beat")

endmodule

`default_nettype wire

// File: design/ptpc_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module ptpc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: tb/sv/tb_point_triangle_penalty_contact_core.sv
// testbench of the point-triangle contact core: triangle loads, queries, register settings
`timescale 1ns / 100ps

module tb_point_triangle_penalty_contact_core;

  typedef longint vec3_t [3];

  typedef struct {
    logic                               hit;
    logic [ptpc_pkg::SLOT_W-1:0]        slot;
    logic [ptpc_pkg::DEPTH_W-1:0]       depth;
    logic [ptpc_pkg::FORCE_W-1:0]       fx;
    logic [ptpc_pkg::FORCE_W-1:0]       fy;
    logic [ptpc_pkg::FORCE_W-1:0]       fz;
  } contact_t;

  // corner code that the block ignores
  localparam logic [1:0] CORNER_NONE = 2'd3;
  localparam logic [ptpc_pkg::EPS_W-1:0] EPS_MAX = {ptpc_pkg::EPS_W{1'b1}};
  localparam int LOADED_SLOTS = 24;
  localparam int TOP_SLOT = ptpc_pkg::TRIANGLES - 1;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [ptpc_pkg::CFG_ADDR_W-1:0] paddr;
  logic [ptpc_pkg::CFG_DATA_W-1:0] pwdata;
  logic [ptpc_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  ptpc_in_if  in_ch ();
  ptpc_out_if out_ch ();

  point_triangle_penalty_contact_core i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch.sink),
    .out_ch  (out_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow copy of the store and registers
  longint          tri_pos [ptpc_pkg::TRIANGLES][3][3];
  bit              corner_loaded [ptpc_pkg::TRIANGLES][3];
  logic [ptpc_pkg::EPS_W-1:0]  thr_reg;
  logic [ptpc_pkg::GAIN_W-1:0] gain_reg;
  logic [ptpc_pkg::OFF_W-1:0]  off_reg;
  logic [ptpc_pkg::OFF_W-1:0]  len_reg;

  contact_t pending_contacts[$];
  int  mismatches;
  bit  calm;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #5000000;
    $display("point_triangle_penalty_contact_core test failed");
    $finish;
  end

  function automatic vec3_t cross3(vec3_t a, vec3_t b);
    vec3_t r;
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
    return r;
  endfunction

  function automatic logic signed [127:0] dot3(vec3_t a, vec3_t b);
    logic signed [127:0] s;
    s = 0;
    for (int i = 0; i < 3; i++) s += 128'(a[i]) * 128'(b[i]);
    return s;
  endfunction

  // rounded, saturated force component
  function automatic logic [ptpc_pkg::FORCE_W-1:0] force_comp(logic signed [127:0] gd,
                                                              longint n);
    logic signed [127:0] f;
    f = gd * 128'(n);
    f = f + (128'sd1 <<< (ptpc_pkg::FORCE_SHIFT - 1));
    f = f >>> ptpc_pkg::FORCE_SHIFT;
    if (f > 128'sd2147483647) return 32'h7fffffff;
    if (f < -128'sd2147483648) return 32'h80000000;
    return f[31:0];
  endfunction

  // first contacting triangle in the configured range
  function automatic contact_t predict_contact(vec3_t p);
    contact_t r;
    int start, stop;
    vec3_t a, b, c, e1, e2, ecb, pa, pb, n;
    logic signed [127:0] eps, dist_v, u, v, w, gd;
    r = '{default: '0};
    eps = 128'(thr_reg);
    start = off_reg / 3;
    stop = (int'(off_reg) + int'(len_reg)) / 3;
    for (int j = start; j < stop && j < ptpc_pkg::TRIANGLES; j++) begin
      for (int i = 0; i < 3; i++) begin
        a[i] = tri_pos[j][0][i];
        b[i] = tri_pos[j][1][i];
        c[i] = tri_pos[j][2][i];
        e1[i] = b[i] - a[i];
        e2[i] = c[i] - a[i];
        ecb[i] = c[i] - b[i];
        pa[i] = p[i] - a[i];
        pb[i] = p[i] - b[i];
      end
      n = cross3(e1, e2);
      dist_v = dot3(n, pa);
      if (dist_v > eps || dist_v < -eps) continue;
      u = dot3(n, cross3(e1, pa));
      v = dot3(n, cross3(pa, e2));
      w = dot3(n, cross3(ecb, pb));
      if (u < 0 || v < 0 || w <= 0) continue;
      gd = (eps - dist_v) * 128'(gain_reg);
      r.hit = 1'b1;
      r.slot = j[ptpc_pkg::SLOT_W-1:0];
      r.depth = dist_v[ptpc_pkg::DEPTH_W-1:0];
      r.fx = force_comp(gd, n[0]);
      r.fy = force_comp(gd, n[1]);
      r.fz = force_comp(gd, n[2]);
      break;
    end
    return r;
  endfunction

  // one beat on the input channel, then the shadow update
  task automatic send_beat(logic kind, int slot, logic [1:0] corner, int x, int y, int z);
    int gap;
    vec3_t p;
    logic signed [ptpc_pkg::COORD_W-1:0] cx, cy, cz;
    gap = 0;
    if (!calm && $urandom_range(99) < 26) gap = $urandom_range(1, 4);
    @(negedge clk);
    while (gap > 0) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
      gap--;
    end
    cx = x[ptpc_pkg::COORD_W-1:0];
    cy = y[ptpc_pkg::COORD_W-1:0];
    cz = z[ptpc_pkg::COORD_W-1:0];
    in_ch.valid = 1'b1;
    in_ch.kind = kind;
    in_ch.tri_slot = slot[ptpc_pkg::SLOT_W-1:0];
    in_ch.corner = corner;
    in_ch.coord_x = cx;
    in_ch.coord_y = cy;
    in_ch.coord_z = cz;
    do @(posedge clk); while (!in_ch.ready);
    p[0] = cx;
    p[1] = cy;
    p[2] = cz;
    if (kind == ptpc_pkg::KIND_LOAD) begin
      if (corner != CORNER_NONE) begin
        for (int i = 0; i < 3; i++) tri_pos[slot[ptpc_pkg::SLOT_W-1:0]][corner][i] = p[i];
        corner_loaded[slot[ptpc_pkg::SLOT_W-1:0]][corner] = 1'b1;
      end
    end else begin
      pending_contacts.push_back(predict_contact(p));
    end
  endtask

  task automatic load_triangle(int slot, vec3_t a, vec3_t b, vec3_t c);
    send_beat(ptpc_pkg::KIND_LOAD, slot, ptpc_pkg::CORNER_A, a[0], a[1], a[2]);
    send_beat(ptpc_pkg::KIND_LOAD, slot, ptpc_pkg::CORNER_B, b[0], b[1], b[2]);
    send_beat(ptpc_pkg::KIND_LOAD, slot, ptpc_pkg::CORNER_C, c[0], c[1], c[2]);
  endtask

  // register write: setup then access cycle
  task automatic cfg_write(logic [1:0] idx, logic [ptpc_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 3'b000};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      ptpc_pkg::REG_THRESHOLD: thr_reg = val[ptpc_pkg::EPS_W-1:0];
      ptpc_pkg::REG_GAIN:      gain_reg = val[ptpc_pkg::GAIN_W-1:0];
      ptpc_pkg::REG_OFFSET:    off_reg = val[ptpc_pkg::OFF_W-1:0];
      ptpc_pkg::REG_LENGTH:    len_reg = val[ptpc_pkg::OFF_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // drop valid, then wait until every result is in and the block has settled
  task automatic drain;
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_contacts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_range(int off, int len, logic [ptpc_pkg::EPS_W-1:0] thr,
                           logic [ptpc_pkg::GAIN_W-1:0] gain);
    drain();
    cfg_write(ptpc_pkg::REG_THRESHOLD, 64'(thr));
    cfg_write(ptpc_pkg::REG_GAIN, 64'(gain));
    cfg_write(ptpc_pkg::REG_OFFSET, 64'(off));
    cfg_write(ptpc_pkg::REG_LENGTH, 64'(len));
  endtask

  function automatic int rand_coord(int spread);
    return int'($urandom_range(2 * spread)) - spread;
  endfunction

  function automatic vec3_t rand_vertex(vec3_t center, int spread);
    vec3_t r;
    for (int i = 0; i < 3; i++) r[i] = center[i] + rand_coord(spread);
    for (int i = 0; i < 3; i++) r[i] = longint'($signed(r[i][ptpc_pkg::COORD_W-1:0]));
    return r;
  endfunction

  task automatic load_random_triangle(int slot);
    vec3_t ctr;
    int spread;
    spread = ($urandom_range(3) == 0) ? 32767 : $urandom_range(16, 8192);
    for (int i = 0; i < 3; i++) ctr[i] = rand_coord(24000);
    load_triangle(slot, rand_vertex(ctr, spread), rand_vertex(ctr, spread),
                  rand_vertex(ctr, spread));
  endtask

  // point on or near a fully loaded triangle of the range, else anywhere
  task automatic send_query;
    int start, stop, j, s, t;
    vec3_t p;
    start = off_reg / 3;
    stop = (int'(off_reg) + int'(len_reg)) / 3;
    if (stop > ptpc_pkg::TRIANGLES) stop = ptpc_pkg::TRIANGLES;
    if (stop > start && $urandom_range(9) < 7) begin
      j = $urandom_range(start, stop - 1);
      s = $urandom_range(16);
      t = $urandom_range(16 - s);
      for (int i = 0; i < 3; i++)
        p[i] = tri_pos[j][0][i] + ((tri_pos[j][1][i] - tri_pos[j][0][i]) * s +
               (tri_pos[j][2][i] - tri_pos[j][0][i]) * t) / 16 +
               (($urandom_range(1) == 0) ? 0 : rand_coord(3));
    end else begin
      for (int i = 0; i < 3; i++) p[i] = rand_coord(32768);
    end
    send_beat(ptpc_pkg::KIND_QUERY, $urandom_range(TOP_SLOT), 2'($urandom_range(3)),
              int'(p[0]), int'(p[1]), int'(p[2]));
  endtask

  // result check against the oldest expectation
  always @(posedge clk) begin
    contact_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_contacts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
      end else begin
        e = pending_contacts.pop_front();
        if (out_ch.hit !== e.hit || out_ch.hit_slot !== e.slot ||
            out_ch.depth !== e.depth || out_ch.force_x !== e.fx ||
            out_ch.force_y !== e.fy || out_ch.force_z !== e.fz) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch at %0t: exp hit %0b slot %0d depth %0d f %0d %0d %0d,",
                      " got hit %0b slot %0d depth %0d f %0d %0d %0d"},
                     $realtime, e.hit, e.slot, $signed(e.depth), $signed(e.fx),
                     $signed(e.fy), $signed(e.fz), out_ch.hit, out_ch.hit_slot,
                     out_ch.depth, out_ch.force_x, out_ch.force_y, out_ch.force_z);
        end
      end
    end
  end

  // result-side stalls
  always @(negedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 26);
  end

  // reset values hold: empty range answers a miss
  task automatic test_reset_defaults;
    thr_reg = ptpc_pkg::EPS_RESET;
    gain_reg = ptpc_pkg::GAIN_RESET;
    off_reg = '0;
    len_reg = '0;
    send_beat(ptpc_pkg::KIND_QUERY, 0, ptpc_pkg::CORNER_A, 0, 0, 0);
    send_beat(ptpc_pkg::KIND_QUERY, TOP_SLOT, CORNER_NONE, -32768, 32767, -1);
  endtask

  // hand-picked triangles and points
  task automatic test_directed_cases;
    vec3_t a, b, c;
    a = '{0, 0, 0};
    b = '{4096, 0, 0};
    c = '{0, 4096, 0};
    load_triangle(0, a, b, c);
    // degenerate triangle: all corners the same
    load_triangle(1, b, b, b);
    // triangle spanning the whole coordinate range
    a = '{-32768, -32768, 0};
    b = '{32767, -32768, 0};
    c = '{-32768, 32767, 0};
    load_triangle(2, a, b, c);
    for (int k = 3; k < LOADED_SLOTS; k++) load_random_triangle(k);
    load_random_triangle(TOP_SLOT);
    // ignored load: corner code three
    send_beat(ptpc_pkg::KIND_LOAD, 0, CORNER_NONE, 32767, 32767, 32767);
    set_range(3, 6, ptpc_pkg::EPS_RESET, ptpc_pkg::GAIN_RESET);
    send_beat(ptpc_pkg::KIND_QUERY, 0, ptpc_pkg::CORNER_A, 1000, 1000, 0);
    send_beat(ptpc_pkg::KIND_QUERY, 0, ptpc_pkg::CORNER_A, 1000, 1000, 1);
    send_beat(ptpc_pkg::KIND_QUERY, 0, ptpc_pkg::CORNER_A, 0, 1000, 0);
    send_beat(ptpc_pkg::KIND_QUERY, 0, ptpc_pkg::CORNER_A, 1000, 1000, -32768);
    send_beat(ptpc_pkg::KIND_QUERY, 0, ptpc_pkg::CORNER_A, 4096, 0, 0);
    send_beat(ptpc_pkg::KIND_QUERY, 0, ptpc_pkg::CORNER_A, -32768, -32768, 0);
    // extremes of threshold and gain saturate the force
    set_range(0, 9, EPS_MAX, '1);
    send_beat(ptpc_pkg::KIND_QUERY, 0, ptpc_pkg::CORNER_A, -32768, -32768, 0);
    send_beat(ptpc_pkg::KIND_QUERY, 0, ptpc_pkg::CORNER_A, 1000, 1000, 100);
    send_beat(ptpc_pkg::KIND_QUERY, 0, ptpc_pkg::CORNER_A, -30000, -30000, -32768);
    set_range(0, 9, '0, '0);
    send_beat(ptpc_pkg::KIND_QUERY, 0, ptpc_pkg::CORNER_A, 1000, 1000, 0);
    send_beat(ptpc_pkg::KIND_QUERY, 0, ptpc_pkg::CORNER_A, 1000, 1000, 1);
    // scan that runs past the end of the store
    set_range(3071, 3072, EPS_MAX, ptpc_pkg::GAIN_RESET);
    send_query();
    send_query();
    // empty range: start equal to end
    set_range(9, 0, EPS_MAX, ptpc_pkg::GAIN_RESET);
    send_beat(ptpc_pkg::KIND_QUERY, 0, ptpc_pkg::CORNER_A, 1000, 1000, 0);
  endtask

  // random settings, each with a mix of queries and loads
  task automatic test_random_phases;
    int off, len, slot;
    logic [ptpc_pkg::EPS_W-1:0] thr;
    logic [ptpc_pkg::GAIN_W-1:0] gain;
    for (int ph = 0; ph < 15; ph++) begin
      calm = (ph >= 6 && ph < 9);
      case ($urandom_range(4))
        0: thr = '0;
        1: thr = EPS_MAX;
        2: thr = ptpc_pkg::EPS_RESET;
        default: thr = ptpc_pkg::EPS_W'({$urandom, $urandom})
                       >> $urandom_range(ptpc_pkg::EPS_W - 1);
      endcase
      case ($urandom_range(3))
        0: gain = '0;
        1: gain = '1;
        default: gain = ptpc_pkg::GAIN_W'($urandom);
      endcase
      if ($urandom_range(5) == 0) begin
        off = $urandom_range(3069, 3071);
        len = $urandom_range(3072);
      end else begin
        off = $urandom_range(3 * LOADED_SLOTS - 1);
        len = $urandom_range(3 * LOADED_SLOTS - off);
      end
      set_range(off, len, thr, gain);
      for (int k = 0; k < 28; k++) begin
        case ($urandom_range(9))
          0: begin
            // reload a triangle that stays fully loaded
            slot = ($urandom_range(7) == 0) ? TOP_SLOT : $urandom_range(LOADED_SLOTS - 1);
            load_random_triangle(slot);
          end
          1: begin
            // stray corner anywhere, outside the scanned slots
            slot = $urandom_range(LOADED_SLOTS, TOP_SLOT - 1);
            send_beat(ptpc_pkg::KIND_LOAD, slot, 2'($urandom_range(3)), rand_coord(32768),
                      rand_coord(32768), rand_coord(32768));
          end
          default: send_query();
        endcase
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    mismatches = 0;
    calm = 1'b0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = ptpc_pkg::KIND_LOAD;
    in_ch.tri_slot = '0;
    in_ch.corner = ptpc_pkg::CORNER_A;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    in_ch.coord_z = '0;
    out_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_defaults();
    test_directed_cases();
    test_random_phases();
    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_contacts.size() == 0) begin
      $display("point_triangle_penalty_contact_core test passed");
    end else begin
      $display("point_triangle_penalty_contact_core test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/ptpc_pkg.sv
design/ptpc_in_if.sv
design/ptpc_out_if.sv
design/ptpc_ram.sv
design/point_triangle_penalty_contact_core.sv
tb/sv/tb_point_triangle_penalty_contact_core.sv
